// ===== sv/mbe_pkg.sv =====
// Shared constants, register layout and controller/datapath structs for the
// Mandelbrot escape-time pixel unit. No dependencies.
package mbe_pkg;

   localparam int COLUMN_W    = 8;
   localparam int ROW_W       = 7;
   localparam int COUNT_W     = 12;
   localparam int COLOR_W     = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam int SCREEN_HEIGHT  = 128;
   localparam int DEF_COLOR_BITS = 8;
   localparam int COLOR_SPREAD   = 345;

   localparam logic [31:0] HIGH_BOUND = 32'h1000_0000;
   localparam logic [31:0] LOW_BOUND  = 32'h0000_1000;

   localparam logic [CSR_INDEX_W-1:0] REG_ORIGIN_REAL   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ORIGIN_IMAG   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_REAL_STEP     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAG_STEP     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_ITER_LIMIT    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_LOW_PRECISION = 3'd5;

   typedef struct packed {
      logic [31:0]        origin_real;
      logic [31:0]        origin_imag;
      logic [30:0]        real_step;
      logic [30:0]        imag_step;
      logic [COUNT_W-1:0] iteration_limit;
      logic               low_precision;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      origin_real:     32'hF700_0000,
      origin_imag:     32'hFB33_3333,
      real_step:       31'h0018_0000,
      imag_step:       31'h0013_3333,
      iteration_limit: 12'd45,
      low_precision:   1'b1
   };

   typedef struct packed {
      logic capture;
      logic mul_re;
      logic mul_im;
      logic setup;
      logic mul_yy;
      logic mul_xy;
      logic advance;
      logic post;
      logic in_set;
   } cmd_type;

   typedef struct packed {
      logic escape;
      logic last;
      logic zero_limit;
   } sts_type;

   typedef struct packed {
      logic [COUNT_W-1:0] escape_count;
      logic               inside_res;
      logic [COLOR_W-1:0] color;
   } rsp_type;

   function automatic logic [31:0] fit(input logic [31:0] v, input logic low);
      return low ? {{16{v[15]}}, v[15:0]} : v;
   endfunction

endpackage

// ===== sv/mbe_if.sv =====
// Valid/ready channels for pixel requests and escape-time responses.
// Depends on mbe_pkg for field widths.
interface mbe_req_if;
   logic                         valid;
   logic                         ready;
   logic [mbe_pkg::COLUMN_W-1:0] column;
   logic [mbe_pkg::ROW_W-1:0]    row;
   modport source(output valid, column, row, input ready);
   modport sink(input valid, column, row, output ready);
endinterface

interface mbe_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [mbe_pkg::COUNT_W-1:0] escape_count;
   logic                        inside_res;
   logic [mbe_pkg::COLOR_W-1:0] color;
   modport source(output valid, escape_count, inside_res, color, input ready);
   modport sink(input valid, escape_count, inside_res, color, output ready);
endinterface

// ===== sv/mbe_ctrl.sv =====
// Sequencer for the escape-time unit: one pixel at a time, four steps per
// iteration over the shared multiplier. Depends on mbe_pkg.
module mbe_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  mbe_pkg::sts_type sts,
   output mbe_pkg::cmd_type cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_MUL_RE = 4'd1;
   localparam logic [3:0] S_MUL_IM = 4'd2;
   localparam logic [3:0] S_SETUP  = 4'd3;
   localparam logic [3:0] S_MUL_XX = 4'd4;
   localparam logic [3:0] S_MUL_YY = 4'd5;
   localparam logic [3:0] S_MUL_XY = 4'd6;
   localparam logic [3:0] S_CHECK  = 4'd7;
   localparam logic [3:0] S_DONE   = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       inside_ff, inside_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      inside_in    = inside_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      cmd.in_set   = inside_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_MUL_RE;
            end
         end
         S_MUL_RE: begin
            cmd.mul_re = 1'b1;
            state_in   = S_MUL_IM;
         end
         S_MUL_IM: begin
            cmd.mul_im = 1'b1;
            state_in   = S_SETUP;
         end
         S_SETUP: begin
            cmd.setup = 1'b1;
            inside_in = sts.zero_limit;
            state_in  = sts.zero_limit ? S_DONE : S_MUL_XX;
         end
         S_MUL_XX: begin
            state_in = S_MUL_YY;
         end
         S_MUL_YY: begin
            cmd.mul_yy = 1'b1;
            state_in   = S_MUL_XY;
         end
         S_MUL_XY: begin
            cmd.mul_xy = 1'b1;
            state_in   = S_CHECK;
         end
         S_CHECK: begin
            if (sts.escape) begin
               state_in = S_DONE;
            end else begin
               cmd.advance = 1'b1;
               if (sts.last) begin
                  inside_in = 1'b1;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_MUL_XX;
               end
            end
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.post     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         inside_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         inside_ff    <= inside_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== sv/mbe_datapath.sv =====
// Datapath of the escape-time unit: point setup, shared signed multiplier,
// z update, escape test, running colour quotient and result word.
// Depends on mbe_pkg.
module mbe_datapath #(
   parameter int COLOR_BITS = mbe_pkg::DEF_COLOR_BITS
) (
   input  logic                         clock,
   input  mbe_pkg::cfg_type             cfg,
   input  mbe_pkg::cmd_type             cmd,
   input  logic [mbe_pkg::COLUMN_W-1:0] column,
   input  logic [mbe_pkg::ROW_W-1:0]    row,
   output mbe_pkg::sts_type             sts,
   output mbe_pkg::rsp_type             rsp
);

   localparam int SPREAD = mbe_pkg::COLOR_SPREAD;
   localparam int STEP_Q = (1 << COLOR_BITS) / SPREAD;
   localparam int STEP_R = (1 << COLOR_BITS) % SPREAD;

   logic [mbe_pkg::COLUMN_W-1:0] column_ff, column_in;
   logic [mbe_pkg::ROW_W-1:0]    row_ff, row_in;
   logic [57:0]                  prod_ff, prod_in;
   logic [31:0]                  a_ff, a_in, b_ff, b_in;
   logic [31:0]                  x_ff, x_in, y_ff, y_in;
   logic [31:0]                  x2_ff, x2_in, y2_ff, y2_in;
   logic [mbe_pkg::COUNT_W-1:0]  n_ff, n_in;
   logic [COLOR_BITS-1:0]        q_ff, q_in;
   logic [8:0]                   r_ff, r_in;
   mbe_pkg::rsp_type             rsp_ff, rsp_in;

   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] prod_full;
   logic [31:0]        rows_up, c_im, prod_fx, sum_sq, bound, x_new, y_new;
   logic [9:0]         r_sum;
   logic [15:0]        color_wide;
   logic               low;

   assign low = cfg.low_precision;

   always_comb begin
      rows_up = 32'(mbe_pkg::SCREEN_HEIGHT - 1) - 32'(row_ff);
      mul_a   = x_ff;
      mul_b   = x_ff;
      if (cmd.mul_re) begin
         mul_a = {1'b0, cfg.real_step};
         mul_b = 32'(column_ff);
      end else if (cmd.mul_im) begin
         mul_a = {1'b0, cfg.imag_step};
         mul_b = rows_up;
      end else if (cmd.mul_yy) begin
         mul_a = y_ff;
         mul_b = y_ff;
      end else if (cmd.mul_xy) begin
         mul_a = x_ff;
         mul_b = y_ff;
      end
      prod_full = mul_a * mul_b;
      prod_in   = prod_full[57:0];
   end

   always_comb begin
      prod_fx = low ? {{16{prod_ff[25]}}, prod_ff[25:10]} : prod_ff[57:26];
      c_im    = cfg.origin_imag + prod_ff[31:0];
      sum_sq  = x2_ff + y2_ff;
      bound   = low ? mbe_pkg::LOW_BOUND : mbe_pkg::HIGH_BOUND;
      y_new   = mbe_pkg::fit({prod_fx[30:0], 1'b0} + b_ff, low);
      x_new   = mbe_pkg::fit(x2_ff - y2_ff + a_ff, low);
      r_sum   = 10'(r_ff) + 10'(STEP_R);
   end

   assign sts.escape     = ($signed(sum_sq) > $signed(bound));
   assign sts.last       = (n_ff == cfg.iteration_limit);
   assign sts.zero_limit = (cfg.iteration_limit == '0);

   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      x2_in     = x2_ff;
      y2_in     = y2_ff;
      n_in      = n_ff;
      q_in      = q_ff;
      r_in      = r_ff;
      rsp_in    = rsp_ff;
      if (cmd.capture) begin
         column_in = column;
         row_in    = row;
      end
      if (cmd.mul_im) begin
         a_in = cfg.origin_real + prod_ff[31:0];
      end
      if (cmd.setup) begin
         a_in = low ? {{16{a_ff[31]}}, a_ff[31:16]} : a_ff;
         x_in = low ? {{16{a_ff[31]}}, a_ff[31:16]} : a_ff;
         b_in = low ? {{16{c_im[31]}}, c_im[31:16]} : c_im;
         y_in = low ? {{16{c_im[31]}}, c_im[31:16]} : c_im;
         n_in = mbe_pkg::COUNT_W'(1);
         q_in = COLOR_BITS'(STEP_Q);
         r_in = 9'(STEP_R);
      end
      if (cmd.mul_yy) begin
         x2_in = prod_fx;
      end
      if (cmd.mul_xy) begin
         y2_in = prod_fx;
      end
      if (cmd.advance) begin
         x_in = x_new;
         y_in = y_new;
         n_in = n_ff + mbe_pkg::COUNT_W'(1);
         if (r_sum >= 10'(SPREAD)) begin
            r_in = 9'(r_sum - 10'(SPREAD));
            q_in = q_ff + COLOR_BITS'(STEP_Q + 1);
         end else begin
            r_in = r_sum[8:0];
            q_in = q_ff + COLOR_BITS'(STEP_Q);
         end
      end
      if (cmd.post) begin
         rsp_in.escape_count = cmd.in_set ? '0 : n_ff;
         rsp_in.inside_res   = cmd.in_set;
         rsp_in.color        = cmd.in_set ? '0 : color_wide[mbe_pkg::COLOR_W-1:0];
      end
   end

   assign color_wide = 16'(q_ff);

   always_ff @(posedge clock) begin
      column_ff <= column_in;
      row_ff    <= row_in;
      prod_ff   <= prod_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      x2_ff     <= x2_in;
      y2_ff     <= y2_in;
      n_ff      <= n_in;
      q_ff      <= q_in;
      r_ff      <= r_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp = rsp_ff;

endmodule

// ===== sv/mandelbrot_escape_time_pixel_unit.sv =====
// Mandelbrot escape-time pixel unit: takes a pixel (column, row) on the
// request channel and returns escape count, inside flag and colour on the
// response channel, one pixel in flight at a time. Each iteration makes
// three dependent products x*x, y*y and x*y on one shared 32x32 signed
// multiplier, then tests and updates z in a step of its own; point setup
// first runs the real and imaginary step products on the multiplier and
// then loads the point, and once the pixel is done the unit posts the
// word and returns to idle. A finished word waits in the output register
// while the next pixel is accepted; a pixel that finishes while that word
// is still unread holds until it is taken.
// Depends on mbe_pkg, mbe_if, mbe_ctrl and mbe_datapath.
module mandelbrot_escape_time_pixel_unit #(
   parameter int COLOR_BITS = mbe_pkg::DEF_COLOR_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   mbe_req_if.sink                         req_if,
   mbe_rsp_if.source                       rsp_if,
   input  logic                            csr_we,
   input  logic [mbe_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mbe_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   mbe_pkg::cfg_type cfg_ff, cfg_in;
   mbe_pkg::cmd_type cmd;
   mbe_pkg::sts_type sts;
   mbe_pkg::rsp_type rsp;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            mbe_pkg::REG_ORIGIN_REAL:   cfg_in.origin_real     = csr_wdata;
            mbe_pkg::REG_ORIGIN_IMAG:   cfg_in.origin_imag     = csr_wdata;
            mbe_pkg::REG_REAL_STEP:     cfg_in.real_step       = csr_wdata[30:0];
            mbe_pkg::REG_IMAG_STEP:     cfg_in.imag_step       = csr_wdata[30:0];
            mbe_pkg::REG_ITER_LIMIT:
               cfg_in.iteration_limit = csr_wdata[mbe_pkg::COUNT_W-1:0];
            mbe_pkg::REG_LOW_PRECISION: cfg_in.low_precision   = csr_wdata[0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= mbe_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mbe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mbe_datapath #(
      .COLOR_BITS (COLOR_BITS)
   ) u_datapath (
      .clock  (clock),
      .cfg    (cfg_ff),
      .cmd    (cmd),
      .column (req_if.column),
      .row    (req_if.row),
      .sts    (sts),
      .rsp    (rsp)
   );

   assign rsp_if.escape_count = rsp.escape_count;
   assign rsp_if.inside_res   = rsp.inside_res;
   assign rsp_if.color        = rsp.color;

endmodule
